### rtl/core/dkps_pkg.sv
// Shared types and sizing constants for the descending key/payload sorter.
package dkps_pkg;

	localparam int CAPACITY     = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int KEY_W        = 32;
	localparam int PAY_IO_W     = 32;
	localparam int PAY_W        = (PAYLOAD_BITS < PAY_IO_W) ? PAYLOAD_BITS : PAY_IO_W;
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [PAY_IO_W-1:0]     pay_io_t;
	typedef logic [PAY_W-1:0]        pay_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef struct packed {
		logic insert;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

### rtl/core/dkps_in_if.sv
// Input channel carrying one key/payload pair per transfer.
interface dkps_in_if;
	logic               valid;
	logic               ready;
	dkps_pkg::key_t     sort_key;
	dkps_pkg::pay_io_t  item_payload;
	logic               final_item;

	modport source (output valid, output sort_key, output item_payload, output final_item,
		input ready);
	modport sink (input valid, input sort_key, input item_payload, input final_item,
		output ready);
endinterface

### rtl/core/dkps_out_if.sv
// Output channel carrying one sorted key/payload pair per transfer.
interface dkps_out_if;
	logic               valid;
	logic               ready;
	dkps_pkg::key_t     sorted_key;
	dkps_pkg::pay_io_t  sorted_payload;
	logic               end_of_run;
	logic               items_dropped;

	modport source (output valid, output sorted_key, output sorted_payload,
		output end_of_run, output items_dropped, input ready);
	modport sink (input valid, input sorted_key, input sorted_payload,
		input end_of_run, input items_dropped, output ready);
endinterface

### rtl/core/dkps_datapath.sv
// Insertion chain of sorted cells, fill count, overflow flag and result register.
module dkps_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dkps_pkg::cmd_t      cmd,
	output dkps_pkg::sts_t      sts,
	input  dkps_pkg::key_t      in_key,
	input  dkps_pkg::pay_io_t   in_payload,
	output dkps_pkg::key_t      res_key,
	output dkps_pkg::pay_io_t   res_payload,
	output logic                res_last,
	output logic                res_dropped
);

	dkps_pkg::key_t key_q [dkps_pkg::CAPACITY];
	dkps_pkg::pay_t pay_q [dkps_pkg::CAPACITY];
	dkps_pkg::cnt_t count_q;
	logic           overflow_q;
	logic           full;
	logic [dkps_pkg::CAPACITY-1:0] gt;

	dkps_pkg::key_t res_key_q;
	dkps_pkg::pay_t res_pay_q;
	logic           res_last_q;
	logic           res_dropped_q;

	assign full     = (count_q == dkps_pkg::CNT_W'(dkps_pkg::CAPACITY));
	assign sts.last = (count_q == dkps_pkg::CNT_W'(1));

	genvar g;
	generate
		for (g = 0; g < dkps_pkg::CAPACITY; g++) begin : gen_cell
			logic           take;
			logic           shift_in;
			dkps_pkg::key_t src_key;
			dkps_pkg::pay_t src_pay;
			dkps_pkg::key_t nxt_key;
			dkps_pkg::pay_t nxt_pay;

			assign gt[g] = (dkps_pkg::CNT_W'(g) < count_q) && (in_key > key_q[g]);
			assign take  = gt[g] || (count_q == dkps_pkg::CNT_W'(g));

			if (g == 0) begin : gen_head
				assign shift_in = 1'b0;
				assign src_key  = in_key;
				assign src_pay  = in_payload[dkps_pkg::PAY_W-1:0];
			end else begin : gen_body
				assign shift_in = gt[g-1];
				assign src_key  = shift_in ? key_q[g-1] : in_key;
				assign src_pay  = shift_in ? pay_q[g-1] : in_payload[dkps_pkg::PAY_W-1:0];
			end

			if (g == dkps_pkg::CAPACITY - 1) begin : gen_tail
				assign nxt_key = key_q[g];
				assign nxt_pay = pay_q[g];
			end else begin : gen_mid
				assign nxt_key = key_q[g+1];
				assign nxt_pay = pay_q[g+1];
			end

			always_ff @(posedge clk) begin
				if (cmd.emit) begin
					key_q[g] <= nxt_key;
					pay_q[g] <= nxt_pay;
				end else if (cmd.insert && !full && take) begin
					key_q[g] <= src_key;
					pay_q[g] <= src_pay;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.emit) begin
			count_q <= count_q - dkps_pkg::CNT_W'(1);
			if (sts.last) begin
				overflow_q <= 1'b0;
			end
		end else if (cmd.insert) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + dkps_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_key_q     <= key_q[0];
			res_pay_q     <= pay_q[0];
			res_last_q    <= sts.last;
			res_dropped_q <= overflow_q;
		end
	end

	assign res_key     = res_key_q;
	assign res_payload = dkps_pkg::PAY_IO_W'(res_pay_q);
	assign res_last    = res_last_q;
	assign res_dropped = res_dropped_q;

	property p_count_bounded;
		@(posedge clk) disable iff (!arst_n)
		count_q <= dkps_pkg::CNT_W'(dkps_pkg::CAPACITY);
	endproperty
	a_count_bounded: assert property (p_count_bounded)
		else $error("fill count exceeds capacity");

	property p_emit_nonempty;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (count_q != '0);
	endproperty
	a_emit_nonempty: assert property (p_emit_nonempty)
		else $error("emit from an empty store");

	property p_full_drop_flags;
		@(posedge clk) disable iff (!arst_n)
		(cmd.insert && full) |=> overflow_q;
	endproperty
	a_full_drop_flags: assert property (p_full_drop_flags)
		else $error("dropped pair did not set the overflow flag");

endmodule

### rtl/core/dkps_ctrl.sv
// Controller that sequences loading, the first emit and the output run.
module dkps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_final,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dkps_pkg::cmd_t  cmd,
	input  dkps_pkg::sts_t  sts
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FIRST,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   in_xfer;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = ((state_q == ST_LOAD) || (state_q == ST_RUN)) && slot_free;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:  cmd.insert = in_xfer;
			ST_FIRST: cmd.emit   = slot_free;
			ST_RUN:   cmd.emit   = in_xfer;
			default:  cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer && in_final) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (cmd.emit) begin
						state_q <= sts.last ? ST_LOAD : ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.emit && sts.last) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	property p_emit_has_slot;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> slot_free;
	endproperty
	a_emit_has_slot: assert property (p_emit_has_slot)
		else $error("result produced while the output register is occupied");

	property p_last_ends_run;
		@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last) |=> (state_q == ST_LOAD);
	endproperty
	a_last_ends_run: assert property (p_last_ends_run)
		else $error("run did not end after its last item");

	property p_emit_shows_result;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q;
	endproperty
	a_emit_shows_result: assert property (p_emit_shows_result)
		else $error("emitted item not presented on the output");

endmodule

### rtl/core/descending_key_payload_sort.sv
// Top level of the descending stable key/payload insertion sorter.
//
//   channel   direction  payload
//   items     in         sort_key, item_payload, final_item
//   results   out        sorted_key, sorted_payload, end_of_run, items_dropped
//
// Loading takes one pair per cycle; the whole cell chain compares and shifts in parallel.
// A waiting result stalls loading; after the final pair ST_FIRST emits the first result.
// During a run every accepted item yields one result, one per cycle at best.
// Reset empties the store and the overflow flag; no clearing pass is needed.
// A stalled results channel holds back items only when the output register is full.
module descending_key_payload_sort (
	input  logic        clk,
	input  logic        arst_n,
	dkps_in_if.sink     items,
	dkps_out_if.source  results
);

	dkps_pkg::cmd_t cmd;
	dkps_pkg::sts_t sts;

	dkps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_final  (items.final_item),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dkps_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_key      (items.sort_key),
		.in_payload  (items.item_payload),
		.res_key     (results.sorted_key),
		.res_payload (results.sorted_payload),
		.res_last    (results.end_of_run),
		.res_dropped (results.items_dropped)
	);

endmodule
